/* rtl/core/nnis_pkg.sv */
// Shared types and constants of the nearest-neighbor scaler.
package nnis_pkg;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [12:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [15:0] RST_SRC_HEIGHT = 16'd480;
  localparam logic [15:0] RST_DST_WIDTH  = 16'd640;
  localparam logic [15:0] RST_DST_HEIGHT = 16'd480;
  localparam logic [2:0]  RST_BPP        = 3'd3;

  // Divider operand widths
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;

  typedef struct packed {
    logic        req_type;
    logic [31:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic        out_valid;
    logic [31:0] pixel_out;
    logic        end_of_line;
    logic        end_of_frame;
    logic        refused;
  } out_beat_t;

endpackage

/* rtl/core/nearest_neighbor_image_scaler_unit.sv */
// Nearest-neighbor raster scaler top level: sequencer, registers and output stage.
// A write that does not end a line, a refused write and an empty drain go from accept straight
//   to the output stage. A write that ends a line first runs two divisions (OP_LO, then OP_HI).
//   A drain that returns a pixel runs one division (OP_COL) plus a store read.
// One beat in flight: the next request is accepted only after the last result is loaded out.
// Reset: async active low; counters clear, registers return to their defaults.
//   The line store is not cleared.
module nearest_neighbor_image_scaler_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  nnis_pkg::in_beat_t                in_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output nnis_pkg::out_beat_t               out_data_o
);
  import nnis_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [31:0] PixMask = 32'((64'd1 << PIXEL_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV_GO, S_DIV_WAIT, S_RD, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_LO, OP_HI, OP_COL
  } op_e;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [12:0] src_width_q;
  logic [15:0] src_height_q;
  logic [15:0] dst_width_q;
  logic [15:0] dst_height_q;
  logic [2:0]  bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      dst_width_q  <= RST_DST_WIDTH;
      dst_height_q <= RST_DST_HEIGHT;
      bpp_q        <= RST_BPP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[12:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i;
        CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i;
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i;
        CFG_BPP:        bpp_q        <= cfg_data_i[2:0];
        default: ;      // unused index, dropped
      endcase
    end
  end

  // Effective sizes: zero reads as one, source width clamped to the store depth
  logic [12:0] sw;
  logic [15:0] sh, dh, dw;
  logic [31:0] pix_mask;

  always_comb begin
    if (src_width_q == '0) begin
      sw = 13'd1;
    end else if ({4'd0, src_width_q} > MaxW) begin
      sw = MaxW[12:0];
    end else begin
      sw = src_width_q;
    end
  end

  assign sh = (src_height_q == '0) ? 16'd1 : src_height_q;
  assign dh = (dst_height_q == '0) ? 16'd1 : dst_height_q;
  assign dw = (dst_width_q  == '0) ? 16'd1 : dst_width_q;

  // byte count clamped to 1..4, then limited to the stored pixel width
  always_comb begin
    unique case (bpp_q)
      3'd2:    pix_mask = 32'h0000_FFFF & PixMask;
      3'd3:    pix_mask = 32'h00FF_FFFF & PixMask;
      3'd4, 3'd5, 3'd6, 3'd7:
               pix_mask = PixMask;
      default: pix_mask = 32'h0000_00FF & PixMask;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------
  state_e      state_q;
  op_e         op_q;
  logic [12:0] wcol_q;        // next source column to write
  logic [15:0] srow_q;        // next source row
  logic [15:0] pend_q;        // destination lines still to drain
  logic [15:0] rcol_q;        // next destination column
  logic [15:0] row_q;         // row of the line just completed
  logic [15:0] lo_q;          // first destination line of that row
  logic [31:0] prod_q;
  out_beat_t   res_q;         // staged result
  out_beat_t   out_q;
  logic        out_full_q;

  logic accept;
  logic is_write;
  logic load_out;

  assign accept   = in_valid_i && in_ready_o;
  assign is_write = in_data_i.req_type == REQ_WRITE;
  assign load_out = (state_q == S_OUT) && (!out_full_q || out_ready_i);

  // Write column, clamped when the width was lowered mid-line
  logic [12:0] wcol_eff;
  logic [13:0] wcol_nxt;
  logic        line_done;
  logic [15:0] row_eff;
  logic [16:0] row_inc;

  assign wcol_eff  = (wcol_q >= sw) ? (sw - 13'd1) : wcol_q;
  assign wcol_nxt  = {1'b0, wcol_eff} + 14'd1;
  assign line_done = wcol_nxt >= {1'b0, sw};
  assign row_eff   = (srow_q >= sh) ? '0 : srow_q;
  assign row_inc   = {1'b0, row_eff} + 17'd1;

  // ---------------------------------------------------------------
  // Shared multiplier operands and divider
  // ---------------------------------------------------------------
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;
  logic        div_start;
  logic [15:0] div_dvs;
  logic        div_done;
  logic [31:0] div_quo;

  always_comb begin
    unique case (op_q)
      OP_LO:   begin mul_a = {1'b0, row_q};          mul_b = dh; end
      OP_HI:   begin mul_a = {1'b0, row_q} + 17'd1;  mul_b = dh; end
      default: begin mul_a = {1'b0, rcol_q};         mul_b = {3'd0, sw}; end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign div_start = state_q == S_DIV_GO;
  assign div_dvs   = (op_q == OP_COL) ? dw : sh;

  nnis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------
  // Line store
  // ---------------------------------------------------------------
  logic                  st_we;
  logic [15:0]           st_wcol;
  logic [PIXEL_BITS-1:0] st_wdata;
  logic                  st_re;
  logic [15:0]           st_rcol;
  logic [PIXEL_BITS-1:0] st_rdata;
  logic [31:0]           wr_pix;

  assign st_we    = accept && is_write && (pend_q == '0);
  assign st_wcol  = {3'd0, wcol_eff};
  assign wr_pix   = in_data_i.pixel_in & pix_mask;
  assign st_wdata = wr_pix[PIXEL_BITS-1:0];
  assign st_re    = (state_q == S_DIV_WAIT) && div_done && (op_q == OP_COL);
  // source column past the source width clamps to the last column
  assign st_rcol  = (div_quo >= {19'd0, sw}) ? {3'd0, sw - 13'd1} : div_quo[15:0];

  nnis_lstore #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_lstore (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_wcol[AW-1:0]),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_rcol[AW-1:0]),
    .rdata_o (st_rdata)
  );

  // Drain bookkeeping at the read step
  logic [16:0] rcol_inc;
  logic        eol;
  logic [15:0] pend_dec;
  logic [31:0] rd_pix;

  assign rcol_inc = {1'b0, rcol_q} + 17'd1;
  assign eol      = rcol_inc >= {1'b0, dw};
  assign pend_dec = pend_q - 16'd1;
  assign rd_pix   = 32'(st_rdata) & pix_mask;

  // ---------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_LO;
      wcol_q     <= '0;
      srow_q     <= '0;
      pend_q     <= '0;
      rcol_q     <= '0;
      row_q      <= '0;
      lo_q       <= '0;
      prod_q     <= '0;
      res_q      <= '0;
      out_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      // result beat leaves or a new one lands
      if (load_out) begin
        out_q      <= res_q;
        out_full_q <= 1'b1;
      end else if (out_ready_i) begin
        out_full_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_write) begin
              if (pend_q != '0) begin
                res_q   <= '{out_valid: 1'b0, pixel_out: '0, end_of_line: 1'b0,
                             end_of_frame: 1'b0, refused: 1'b1};
                state_q <= S_OUT;
              end else if (line_done) begin
                // line complete: work out how many destination lines it makes
                res_q   <= '0;
                wcol_q  <= '0;
                row_q   <= row_eff;
                srow_q  <= (row_inc >= {1'b0, sh}) ? '0 : row_inc[15:0];
                op_q    <= OP_LO;
                state_q <= S_MUL;
              end else begin
                res_q   <= '0;
                wcol_q  <= wcol_nxt[12:0];
                state_q <= S_OUT;
              end
            end else if (pend_q == '0) begin
              res_q   <= '0;
              state_q <= S_OUT;       // nothing to drain
            end else begin
              res_q   <= '0;
              op_q    <= OP_COL;
              state_q <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod_q  <= mul_p[31:0];
          state_q <= S_DIV_GO;
        end

        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (op_q)
              OP_LO: begin
                lo_q    <= div_quo[15:0];
                op_q    <= OP_HI;
                state_q <= S_MUL;
              end
              OP_HI: begin
                pend_q  <= div_quo[15:0] - lo_q;
                state_q <= S_OUT;
              end
              default: begin
                state_q <= S_RD;        // store read under way
              end
            endcase
          end
        end

        S_RD: begin
          res_q.out_valid <= 1'b1;
          res_q.pixel_out <= rd_pix;
          if (eol) begin
            res_q.end_of_line  <= 1'b1;
            res_q.end_of_frame <= (pend_dec == '0) && (srow_q == '0);
            rcol_q             <= '0;
            pend_q             <= pend_dec;
          end else begin
            rcol_q <= rcol_inc[15:0];
          end
          state_q <= S_OUT;
        end

        S_OUT: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_full_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/nnis_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module nnis_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [nnis_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [nnis_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [nnis_pkg::DIVIDEND_W-1:0] quotient_o
);
  import nnis_pkg::*;

  localparam int unsigned CntW = $clog2(DIVIDEND_W);
  localparam logic [CntW-1:0] LastCnt = CntW'(DIVIDEND_W - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVIDEND_W-1:0] quo_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;
  logic [DIVISOR_W:0]    rem_sub;

  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/nnis_lstore.sv */
// Line store: one write port, one registered read port.
module nnis_lstore #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* bench/tb.sv */
// Self-checking testbench for the nearest-neighbor image scaler unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnis_pkg::*;

  localparam int unsigned MAX_W = 4096;

  // ---------------------------------------------------------------------------
  // DUT connections. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_beat_t             out_data_o;

  nearest_neighbor_image_scaler_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns period
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scaler predictor: shadow registers and state, updated at each accepted
  // request beat in acceptance order.
  // ---------------------------------------------------------------------------
  logic [12:0] cf_src_w = RST_SRC_WIDTH;
  logic [15:0] cf_src_h = RST_SRC_HEIGHT;
  logic [15:0] cf_dst_w = RST_DST_WIDTH;
  logic [15:0] cf_dst_h = RST_DST_HEIGHT;
  logic [2:0]  cf_bpp   = RST_BPP;

  logic [31:0] store_px [MAX_W] = '{default: '0};
  logic [12:0] wr_col     = '0;  // next column of the line being filled
  logic [15:0] src_row    = '0;  // source row the next full line stands for
  logic [15:0] lines_owed = '0;  // destination lines still to drain
  logic [15:0] rd_col     = '0;  // next destination column
  logic [15:0] dst_row    = '0;  // destination lines drained this frame

  // Results expected from the DUT, oldest first
  out_beat_t scaler_replies [$];

  // Run bookkeeping
  int  err_count = 0;
  int  n_beats   = 0;
  int  n_cfg     = 0;
  int  n_pixels  = 0;
  int  n_eol     = 0;
  int  n_eof     = 0;
  int  n_refused = 0;
  int  n_empty   = 0;
  bit  in_held   = 1'b0;  // valid still high from the last accepted beat
  bit  steady    = 1'b0;  // no random idling on either side while set
  int  sink_hold = 0;     // long receiver hold-off, counted down by the sink

  function automatic int unsigned eff_src_w();
    if (cf_src_w == 0) return 1;
    if (cf_src_w > MAX_W) return MAX_W;
    return cf_src_w;
  endfunction

  // Only the low bytes_per_pixel bytes survive; 0 counts as 1, above 4 as 4
  function automatic logic [31:0] keep_mask();
    int unsigned nbytes;
    nbytes = (cf_bpp == 0) ? 1 : ((cf_bpp > 4) ? 4 : cf_bpp);
    return (nbytes >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (nbytes * 8)) - 32'd1);
  endfunction

  function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SRC_WIDTH:  cf_src_w = val[12:0];
      CFG_SRC_HEIGHT: cf_src_h = val[15:0];
      CFG_DST_WIDTH:  cf_dst_w = val[15:0];
      CFG_DST_HEIGHT: cf_dst_h = val[15:0];
      CFG_BPP:        cf_bpp   = val[2:0];
      default: ;
    endcase
  endfunction

  // One request beat in, one result beat out
  function automatic out_beat_t nn_scale_step(in_beat_t b);
    out_beat_t       r;
    int unsigned     sw;
    longint unsigned sh, dh, dw, row, col;
    r  = '0;
    sw = eff_src_w();
    if (b.req_type == REQ_WRITE) begin
      // previous line not fully drained yet: pixel dropped, flagged
      if (lines_owed != 0) begin
        r.refused = 1'b1;
        return r;
      end
      // width lowered mid-line: pixel lands in the last column
      if (wr_col >= sw) wr_col = 13'(sw - 1);
      store_px[wr_col] = b.pixel_in & keep_mask();
      wr_col++;
      if (wr_col >= sw) begin
        sh  = (cf_src_h == 0) ? 1 : cf_src_h;
        dh  = (cf_dst_h == 0) ? 1 : cf_dst_h;
        // height lowered under the current row: restart at row 0
        row = (src_row >= sh) ? 0 : src_row;
        lines_owed = 16'(((row + 1) * dh / sh) - (row * dh / sh));
        wr_col  = '0;
        src_row = (row + 1 >= sh) ? 16'd0 : 16'(row + 1);
      end
      return r;
    end
    // drain with nothing owed: all-zero result
    if (lines_owed == 0) return r;
    dw  = (cf_dst_w == 0) ? 1 : cf_dst_w;
    col = 64'(rd_col) * sw / dw;
    if (col >= sw) col = sw - 1;
    r.out_valid = 1'b1;
    r.pixel_out = store_px[col] & keep_mask();
    // last column, or past a lowered destination width
    if (64'(rd_col) + 1 >= dw) begin
      r.end_of_line = 1'b1;
      rd_col = '0;
      lines_owed--;
      if (dst_row != 16'hFFFF) dst_row++;
      if (lines_owed == 0 && src_row == 0) begin
        r.end_of_frame = 1'b1;
        dst_row = '0;
      end
    end else begin
      rd_col++;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly back-to-back or short gaps, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int rand_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one beat, waits for the handshake and records what it should give.
  // Valid stays high on exit so that the next beat can follow with no gap;
  // anything that lets time pass without sending calls release_input first.
  task automatic send_beat(input logic kind, input logic [31:0] px);
    in_beat_t b;
    int       gap;
    b.req_type = kind;
    b.pixel_in = px;
    gap = rand_gap();
    if (gap > 0) begin
      if (in_held) in_valid_i <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    in_held = 1'b1;
    scaler_replies.push_back(nn_scale_step(b));
    n_beats++;
  endtask

  task automatic release_input();
    if (in_held) in_valid_i <= 1'b0;
    in_held = 1'b0;
  endtask

  // Block idle: every result back, plus a few spare cycles
  task automatic settle();
    release_input();
    while (scaler_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; the leading edge keeps back-to-back writes to one
  // nonblocking update of the enable per time step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_setting(idx, val);
    n_cfg++;
  endtask

  // Full source lines, each drained completely before the next
  task automatic scan_rows(input int rows);
    repeat (rows) begin
      repeat (eff_src_w()) send_beat(REQ_WRITE, $urandom);
      while (lines_owed != 0) send_beat(REQ_DRAIN, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off on request, in-order compare
  // ---------------------------------------------------------------------------
  task automatic check_reply(input out_beat_t got);
    out_beat_t want;
    if (scaler_replies.size() == 0) begin
      $error("result beat %h with nothing expected", got);
      err_count++;
      return;
    end
    want = scaler_replies.pop_front();
    if (got.out_valid !== want.out_valid) begin
      $error("out_valid: expected %0b, got %0b", want.out_valid, got.out_valid);
      err_count++;
    end
    if (got.pixel_out !== want.pixel_out) begin
      $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
      err_count++;
    end
    if (got.end_of_line !== want.end_of_line) begin
      $error("end_of_line: expected %0b, got %0b", want.end_of_line, got.end_of_line);
      err_count++;
    end
    if (got.end_of_frame !== want.end_of_frame) begin
      $error("end_of_frame: expected %0b, got %0b", want.end_of_frame, got.end_of_frame);
      err_count++;
    end
    if (got.refused !== want.refused) begin
      $error("refused: expected %0b, got %0b", want.refused, got.refused);
      err_count++;
    end
    if (want.out_valid) n_pixels++;
    if (want.end_of_line) n_eol++;
    if (want.end_of_frame) n_eof++;
    if (want.refused) n_refused++;
    if (!want.out_valid && !want.refused) n_empty++;
  endtask

  // Values read right after the edge are the ones the DUT sampled there.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        check_reply(out_data_o);
        stall = rand_gap();
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: empty drain, partial line, then the source width lowered
  // under the write column so the next pixel closes the line in its last
  // column; a write while lines are owed is refused; drain past the line.
  task automatic test_empty_and_refused();
    send_beat(REQ_DRAIN, 32'hFFFF_FFFF);
    send_beat(REQ_WRITE, 32'h0000_0000);
    send_beat(REQ_WRITE, 32'hFFFF_FFFF);
    send_beat(REQ_WRITE, 32'hA5A5_A5A5);
    send_beat(REQ_WRITE, 32'h5A5A_5A5A);
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'd3);
    cfg_write(CFG_DST_WIDTH, 16'd5);
    send_beat(REQ_WRITE, 32'hFFFF_FFFF);
    send_beat(REQ_WRITE, 32'h1234_5678);
    repeat (5) send_beat(REQ_DRAIN, 32'h0);
    send_beat(REQ_DRAIN, 32'h0);
  endtask

  // Zero in every register; bytes per pixel above 4 and a plain 2
  task automatic test_register_clamps();
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'd0);
    cfg_write(CFG_SRC_HEIGHT, 16'd0);
    cfg_write(CFG_DST_WIDTH, 16'd0);
    cfg_write(CFG_DST_HEIGHT, 16'd0);
    cfg_write(CFG_BPP, 16'd0);
    // source row now beyond the one-line height: treated as row 0
    send_beat(REQ_WRITE, 32'hFFFF_FFFF);
    send_beat(REQ_DRAIN, 32'h0);
    settle();
    cfg_write(CFG_BPP, 16'hFFFF);
    send_beat(REQ_WRITE, 32'hDEAD_BEEF);
    send_beat(REQ_DRAIN, 32'h0);
    settle();
    cfg_write(CFG_BPP, 16'd2);
    send_beat(REQ_WRITE, 32'h1234_5678);
    send_beat(REQ_DRAIN, 32'h0);
  endtask

  // 3 source rows onto 2: the first row is dropped, the last ends the frame
  task automatic test_frame_edges();
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'd1);
    cfg_write(CFG_DST_WIDTH, 16'd2);
    cfg_write(CFG_SRC_HEIGHT, 16'd3);
    cfg_write(CFG_DST_HEIGHT, 16'd2);
    send_beat(REQ_WRITE, 32'h0000_00FF);
    send_beat(REQ_DRAIN, 32'h0);
    send_beat(REQ_WRITE, 32'h00FF_FF00);
    repeat (2) send_beat(REQ_DRAIN, 32'h0);
    send_beat(REQ_WRITE, 32'h00AA_5500);
    repeat (2) send_beat(REQ_DRAIN, 32'h0);
  endtask

  // Overrange source width (clamped to the store depth) and the widest
  // destination; the source width then drops under the write column so the
  // next pixel closes the line, and later the destination width drops under
  // the read column, which ends the line on a source column clamped to the
  // last one.
  task automatic test_wide_line();
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'hFFFF);
    cfg_write(CFG_SRC_HEIGHT, 16'd1);
    cfg_write(CFG_DST_HEIGHT, 16'd1);
    cfg_write(CFG_DST_WIDTH, 16'hFFFF);
    cfg_write(CFG_BPP, 16'd4);
    repeat (40) send_beat(REQ_WRITE, $urandom);
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'd24);
    send_beat(REQ_WRITE, $urandom);
    repeat (20) send_beat(REQ_DRAIN, $urandom);
    settle();
    cfg_write(CFG_DST_WIDTH, 16'd12);
    send_beat(REQ_DRAIN, $urandom);
  endtask

  // Tallest frame, then the height lowered under the current row
  task automatic test_tall_frames();
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'd2);
    cfg_write(CFG_DST_WIDTH, 16'd2);
    cfg_write(CFG_SRC_HEIGHT, 16'hFFFF);
    cfg_write(CFG_DST_HEIGHT, 16'hFFFF);
    cfg_write(CFG_BPP, 16'd3);
    scan_rows(2);
    settle();
    cfg_write(CFG_SRC_HEIGHT, 16'd2);
    cfg_write(CFG_DST_HEIGHT, 16'd3);
    scan_rows(2);
  endtask

  // Receiver holds off for a long stretch while requests keep coming,
  // so the unit fills and drops in_ready.
  task automatic test_backpressure();
    settle();
    cfg_write(CFG_SRC_WIDTH, 16'd3);
    cfg_write(CFG_DST_WIDTH, 16'd4);
    steady    = 1'b1;
    sink_hold = 400;
    scan_rows(4);
    steady = 1'b0;
  endtask

  task automatic pick_settings();
    logic [12:0] w;
    // source width only moves while no line is owed, so every store
    // column read back has been written
    if (lines_owed == 0 && $urandom_range(0, 2) != 0) begin
      w = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(9, 48))
                                       : 13'($urandom_range(0, 8));
      cfg_write(CFG_SRC_WIDTH, {3'($urandom), w});
    end
    if ($urandom_range(0, 2) != 0) cfg_write(CFG_SRC_HEIGHT, 16'($urandom_range(0, 5)));
    if ($urandom_range(0, 2) != 0) cfg_write(CFG_DST_HEIGHT, 16'($urandom_range(0, 8)));
    if ($urandom_range(0, 2) != 0)
      cfg_write(CFG_DST_WIDTH, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(11, 40))
                                                           : 16'($urandom_range(0, 10)));
    if ($urandom_range(0, 2) != 0) cfg_write(CFG_BPP, 16'($urandom));
  endtask

  // Bursts that follow the owed-line count, so most traffic is whole lines
  // written then drained, with stray drains and refused writes mixed in.
  // Settings change between bursts, often mid-line or mid-frame.
  task automatic test_random_traffic();
    int   sent;
    int   burst;
    logic kind;
    sent = 0;
    while (sent < 1000) begin
      settle();
      pick_settings();
      steady = ($urandom_range(0, 4) == 0);
      burst  = $urandom_range(15, 90);
      repeat (burst) begin
        if (lines_owed != 0) kind = ($urandom_range(0, 99) < 92) ? REQ_DRAIN : REQ_WRITE;
        else                 kind = ($urandom_range(0, 99) < 92) ? REQ_WRITE : REQ_DRAIN;
        send_beat(kind, $urandom);
      end
      sent += burst;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_refused();
    test_register_clamps();
    test_frame_edges();
    test_wide_line();
    test_tall_frames();
    test_backpressure();
    test_random_traffic();

    // drain what is left, with a bound, then allow for the longest latency
    release_input();
    for (int i = 0; i < 200000 && scaler_replies.size() != 0; i++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (scaler_replies.size() != 0) begin
      $error("%0d expected results never arrived", scaler_replies.size());
      err_count++;
    end

    $display("Sent %0d request beats around %0d register writes: clamps, frame edges, stalls",
             n_beats, n_cfg);
    $display("Checked %0d pixels, %0d line ends, %0d frame ends, %0d refused, %0d empty",
             n_pixels, n_eol, n_eof, n_refused, n_empty);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
